### src/pfr_pkg.sv
// ----------------------------------------------------------------------------
// pfr_pkg
// Shared types, constants and the likelihood table of the particle filter
// resampler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pfr_pkg;

  localparam int PARTICLE_COUNT  = 64;
  localparam int EXP_TABLE_DEPTH = 256;
  localparam int EXP_LOG2        = $clog2(EXP_TABLE_DEPTH);
  localparam int IDX_W           = 6;
  localparam int LIK_W           = 16;
  localparam int SUM_W           = 22;
  localparam int ACC_W           = 45;
  localparam int WN_W            = 23;
  localparam int QS_W            = 38;
  localparam int D2_W            = 34;
  localparam int D2_SHIFT        = 21 - EXP_LOG2;
  localparam int LIDX_W          = D2_W - D2_SHIFT;
  localparam int ARG_SPAN        = 16;
  localparam int TAYLOR_TERMS    = 20;

  // command codes
  localparam logic [1:0] CMD_RESET   = 2'd0;
  localparam logic [1:0] CMD_PREDICT = 2'd1;
  localparam logic [1:0] CMD_UPDATE  = 2'd2;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [5:0]         particle_sel;
    logic signed [15:0] noise_x;
    logic signed [15:0] noise_y;
    logic signed [15:0] noise_heading;
    logic signed [15:0] meas_x;
    logic signed [15:0] meas_y;
    logic [15:0]        offset_frac;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         slot;
    logic [5:0]         source_slot;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] heading;
    logic               degenerate;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] h;
  } pose_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic clear_valid;
    logic p_rd;
    logic p_wr;
    logic l_start;
    logic l_issue;
    logic r_init;
    logic r_c0;
    logic r_cmp;
    logic r_load;
    logic swap;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic k_last;
    logic lik_done;
    logic advance;
    logic out_free;
    logic m_last;
  } stat_t;

  // saturating 16-bit add
  function automatic logic signed [15:0] sat_add(input logic signed [15:0] a,
                                                 input logic signed [15:0] b);
    logic signed [16:0] s;
    s = {a[15], a} + {b[15], b};
    if (s > 17'sd32767) return 16'sh7fff;
    else if (s < -17'sd32768) return 16'sh8000;
    else return s[15:0];
  endfunction

  // restoring divide, elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-f) in Q30 from a truncated Taylor series
  function automatic logic [63:0] exp_neg_q30(input logic [63:0] f);
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] t;
    pos = 64'd1 << 30;
    neg = '0;
    t   = 64'd1 << 30;
    for (int j = 1; j <= TAYLOR_TERMS; j++) begin
      t = udiv64((t * f) >> 30, 64'(j));
      if ((j & 1) != 0) neg = neg + t;
      else pos = pos + t;
    end
    return (neg > pos) ? 64'd0 : pos - neg;
  endfunction

  typedef logic [LIK_W-1:0] exp_rom_t [EXP_TABLE_DEPTH];

  // likelihood table exp(-a), a spanning [0,16), Q1.15
  function automatic exp_rom_t build_exp_rom();
    exp_rom_t    rom;
    logic [63:0] e1;
    logic [63:0] arg;
    logic [63:0] v;
    logic [63:0] whole;
    e1 = exp_neg_q30(64'd1 << 30);
    for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
      arg   = (64'(k) * 64'(ARG_SPAN)) << (30 - EXP_LOG2);
      v     = exp_neg_q30(arg & ((64'd1 << 30) - 64'd1));
      whole = arg >> 30;
      for (int n = 0; n < ARG_SPAN; n++) begin
        if (64'(n) < whole) v = (v * e1) >> 30;
      end
      v = (v + (64'd1 << 14)) >> 15;
      if (v > 64'd32768) v = 64'd32768;
      rom[k] = v[LIK_W-1:0];
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

`default_nettype wire

### src/particle_filter_resampler.sv
// ----------------------------------------------------------------------------
// particle_filter_resampler
// Pose particle filter with likelihood weighting and systematic resampling.
// ----------------------------------------------------------------------------
// Usage: commands arrive on the in channel (in_valid/in_ready/in_data), one
// transfer per command. Resampled particles leave on the out channel
// (out_valid/out_ready/out_data), one transfer per particle.
// Reset command: clears all particles at once, no output.
// Predict command: capture, memory read and saturating write,
// no output; a particle index beyond the set is ignored.
// Update command: the particles stream through the likelihood pipeline
// (particle read, differences, squares, table lookup, store), then the
// systematic resampling walk runs its cumulative-sum steps (at most
// PARTICLE_COUNT-1 in total) and emits each particle from a compare state
// and a load state.
// A new command is taken only once the previous one has finished.
// The output register holds a result while out_ready is low and the walk
// waits; nothing is lost or repeated. rst (synchronous) zeroes all particles
// through their valid bits and returns the sequencer to idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module particle_filter_resampler (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  pfr_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pfr_pkg::out_item_t out_data
);
  import pfr_pkg::*;

  ctl_t  ctl;
  stat_t stat;

  // sequencer
  pfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .stat     (stat),
    .ctl      (ctl)
  );

  // storage and arithmetic
  pfr_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .in_data   (in_data),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### src/pfr_ctrl.sv
// ----------------------------------------------------------------------------
// pfr_ctrl
// Sequencer for reset, predict and update commands of the resampler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  pfr_pkg::in_item_t in_data,
  input  pfr_pkg::stat_t   stat,
  output pfr_pkg::ctl_t    ctl
);
  import pfr_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_P_RD   = 9'b000000010,
    S_P_WR   = 9'b000000100,
    S_L_RUN  = 9'b000001000,
    S_L_WAIT = 9'b000010000,
    S_R_INIT = 9'b000100000,
    S_R_C0   = 9'b001000000,
    S_R_CMP  = 9'b010000000,
    S_R_LOAD = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   sel_ok;

  assign in_ready = (state == S_IDLE);
  assign sel_ok   = {1'b0, in_data.particle_sel} < 7'(PARTICLE_COUNT);

  // next state and commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.capture = 1'b1;
          priority if (in_data.cmd == CMD_RESET) begin
            ctl.clear_valid = 1'b1;
          end else if (in_data.cmd == CMD_PREDICT) begin
            if (sel_ok) state_next = S_P_RD;
          end else if (in_data.cmd == CMD_UPDATE) begin
            ctl.l_start = 1'b1;
            state_next  = S_L_RUN;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_P_RD: begin
        ctl.p_rd   = 1'b1;
        state_next = S_P_WR;
      end
      S_P_WR: begin
        ctl.p_wr   = 1'b1;
        state_next = S_IDLE;
      end
      S_L_RUN: begin
        ctl.l_issue = 1'b1;
        if (stat.k_last) state_next = S_L_WAIT;
      end
      S_L_WAIT: begin
        if (stat.lik_done) state_next = S_R_INIT;
      end
      S_R_INIT: begin
        ctl.r_init = 1'b1;
        state_next = S_R_C0;
      end
      S_R_C0: begin
        ctl.r_c0   = 1'b1;
        state_next = S_R_CMP;
      end
      S_R_CMP: begin
        ctl.r_cmp = 1'b1;
        if (!stat.advance) state_next = S_R_LOAD;
      end
      S_R_LOAD: begin
        if (stat.out_free) begin
          ctl.r_load = 1'b1;
          if (stat.m_last) begin
            ctl.swap   = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_R_CMP;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

`default_nettype wire

### src/pfr_datapath.sv
// ----------------------------------------------------------------------------
// pfr_datapath
// Particle memory, likelihood pipeline, resampling walk and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfr_datapath (
  input  logic               clk,
  input  logic               rst,
  input  pfr_pkg::ctl_t      ctl,
  input  pfr_pkg::in_item_t  in_data,
  output pfr_pkg::stat_t     stat,
  output logic               out_valid,
  input  logic               out_ready,
  output pfr_pkg::out_item_t out_data
);
  import pfr_pkg::*;

  in_item_t cap;

  // particle memory: two banks, current one selected by bank
  pose_t                     pmem [2**(IDX_W+1)];
  logic [PARTICLE_COUNT-1:0] valid;
  logic                      bank;
  pose_t                     pmem_rd;
  logic                      pv_rd;
  pose_t                     p_cur;
  pose_t                     pred;
  logic [IDX_W-1:0]          p_ridx;

  // likelihood pipeline
  logic [IDX_W-1:0]          k;
  logic                      v1, v2, v3, v4;
  logic [IDX_W-1:0]          k1, k2, k3, k4;
  logic signed [16:0]        dx, dy;
  logic signed [33:0]        sqx, sqy;
  logic [D2_W-1:0]           d2;
  logic [LIDX_W-1:0]         lidx;
  logic [LIK_W-1:0]          lik4;
  logic [LIK_W-1:0]          lmem [PARTICLE_COUNT];
  logic [SUM_W-1:0]          sum;

  // resampling walk
  logic [IDX_W-1:0]          i;
  logic [IDX_W-1:0]          m;
  logic [IDX_W-1:0]          l_raddr;
  logic [LIK_W-1:0]          lik_rd;
  logic [LIK_W-1:0]          w;
  logic [WN_W-1:0]           wn;
  logic [ACC_W-1:0]          lhs, rhs;
  logic [SUM_W-1:0]          s_eff, s_c;
  logic [QS_W-1:0]           qs;
  logic                      degen;
  logic                      advance;
  logic                      sum_zero;

  // input capture
  always_ff @(posedge clk) begin
    if (ctl.capture) cap <= in_data;
  end

  // particle read port
  always_comb begin
    priority if (ctl.p_rd) p_ridx = cap.particle_sel;
    else if (ctl.l_issue) p_ridx = k;
    else p_ridx = i;
  end

  always_ff @(posedge clk) begin
    pmem_rd <= pmem[{bank, p_ridx}];
    pv_rd   <= valid[p_ridx];
  end

  assign p_cur  = pv_rd ? pmem_rd : '0;
  assign pred.x = sat_add(p_cur.x, cap.noise_x);
  assign pred.y = sat_add(p_cur.y, cap.noise_y);
  assign pred.h = sat_add(p_cur.h, cap.noise_heading);

  // particle write port
  always_ff @(posedge clk) begin
    if (ctl.p_wr) pmem[{bank, cap.particle_sel}] <= pred;
    else if (ctl.r_load) pmem[{~bank, m}] <= p_cur;
  end

  // valid bits and bank select
  always_ff @(posedge clk) begin
    if (rst || ctl.clear_valid) begin
      valid <= '0;
      if (rst) bank <= 1'b0;
    end else if (ctl.swap) begin
      valid <= '1;
      bank  <= ~bank;
    end else if (ctl.p_wr) begin
      valid[cap.particle_sel] <= 1'b1;
    end
  end

  // likelihood issue counter
  always_ff @(posedge clk) begin
    if (ctl.l_start) k <= '0;
    else if (ctl.l_issue) k <= k + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= ctl.l_issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // differences, squares, table lookup
  assign d2   = D2_W'(unsigned'(sqx)) + D2_W'(unsigned'(sqy));
  assign lidx = d2[D2_W-1:D2_SHIFT];

  always_ff @(posedge clk) begin
    k1   <= k;
    k2   <= k1;
    k3   <= k2;
    k4   <= k3;
    dx   <= {p_cur.x[15], p_cur.x} - {cap.meas_x[15], cap.meas_x};
    dy   <= {p_cur.y[15], p_cur.y} - {cap.meas_y[15], cap.meas_y};
    sqx  <= dx * dx;
    sqy  <= dy * dy;
    lik4 <= (lidx[LIDX_W-1:EXP_LOG2] == '0) ? EXP_ROM[lidx[EXP_LOG2-1:0]] : '0;
  end

  // likelihood store and running sum
  always_ff @(posedge clk) begin
    if (v4) lmem[k4] <= lik4;
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.l_start) sum <= '0;
    else if (v4) sum <= sum + SUM_W'(lik4);
  end

  // likelihood read; from the first compare on, the registered value is one ahead of the walk index
  always_comb begin
    priority if (ctl.r_init) l_raddr = '0;
    else if (ctl.r_cmp && advance) l_raddr = i + IDX_W'(2);
    else l_raddr = i + 1'b1;
  end

  always_ff @(posedge clk) begin
    lik_rd <= lmem[l_raddr];
  end

  assign sum_zero = (sum == '0);
  assign s_c      = sum_zero ? SUM_W'(PARTICLE_COUNT) : sum;
  assign qs       = cap.offset_frac * s_c;
  assign w        = degen ? LIK_W'(1) : lik_rd;
  assign wn       = WN_W'(w) * WN_W'(PARTICLE_COUNT);
  assign advance  = (lhs > rhs) && (i != IDX_W'(PARTICLE_COUNT - 1));

  // walk registers
  always_ff @(posedge clk) begin
    if (ctl.r_init) begin
      i     <= '0;
      m     <= '0;
      degen <= sum_zero;
      s_eff <= s_c;
      lhs   <= ACC_W'(qs);
    end else if (ctl.r_c0) begin
      rhs <= ACC_W'(wn) << 16;
    end else if (ctl.r_cmp && advance) begin
      i   <= i + 1'b1;
      rhs <= rhs + (ACC_W'(wn) << 16);
    end else if (ctl.r_load) begin
      m   <= m + 1'b1;
      lhs <= lhs + (ACC_W'(s_eff) << 16);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (ctl.r_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (ctl.r_load) begin
      out_data.slot        <= m;
      out_data.source_slot <= i;
      out_data.pos_x       <= p_cur.x;
      out_data.pos_y       <= p_cur.y;
      out_data.heading     <= p_cur.h;
      out_data.degenerate  <= degen;
      out_data.last        <= (m == IDX_W'(PARTICLE_COUNT - 1));
    end
  end

  assign stat.k_last   = (k == IDX_W'(PARTICLE_COUNT - 1));
  assign stat.lik_done = v4 && (k4 == IDX_W'(PARTICLE_COUNT - 1));
  assign stat.advance  = advance;
  assign stat.out_free = !out_valid || out_ready;
  assign stat.m_last   = (m == IDX_W'(PARTICLE_COUNT - 1));

  // the walk index only moves forward by one
  a_walk_step: assert property (@(posedge clk) disable iff (rst)
    ctl.r_cmp && advance |=> i == $past(i) + 1'b1)
    else $error("walk index step");

  // a finished run leaves the whole new bank valid
  a_swap_valid: assert property (@(posedge clk) disable iff (rst)
    ctl.swap |=> &valid)
    else $error("bank swap left invalid entries");

  // last flag only on the final slot
  a_last_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.last |-> out_data.slot == IDX_W'(PARTICLE_COUNT - 1))
    else $error("last flag on wrong slot");

endmodule

`default_nettype wire
